>>> hdl/elr_pkg.sv
package elr_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned TERM_BITS      = 48;

  localparam int unsigned PH_BITS = 2;
  localparam logic [PH_BITS-1:0] PH_MAIN = 2'd0;
  localparam logic [PH_BITS-1:0] PH_TAIL = 2'd1;
  localparam logic [PH_BITS-1:0] PH_DONE = 2'd2;

  localparam int unsigned PC_BITS = 4;
  localparam logic [PC_BITS-1:0] PC_IDLE  = 4'd0;
  localparam logic [PC_BITS-1:0] PC_START = 4'd1;
  localparam logic [PC_BITS-1:0] PC_S1    = 4'd2;
  localparam logic [PC_BITS-1:0] PC_S2    = 4'd3;
  localparam logic [PC_BITS-1:0] PC_S3    = 4'd4;
  localparam logic [PC_BITS-1:0] PC_S4    = 4'd5;
  localparam logic [PC_BITS-1:0] PC_MAIN  = 4'd6;
  localparam logic [PC_BITS-1:0] PC_M1    = 4'd7;
  localparam logic [PC_BITS-1:0] PC_M2    = 4'd8;
  localparam logic [PC_BITS-1:0] PC_M3    = 4'd9;
  localparam logic [PC_BITS-1:0] PC_TAIL  = 4'd10;
  localparam logic [PC_BITS-1:0] PC_T1    = 4'd11;
  localparam logic [PC_BITS-1:0] PC_DONE  = 4'd12;

  typedef enum logic [1:0] {
    SEQ_WAIT,
    SEQ_NEXT,
    SEQ_RET
  } seq_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_ST_AA,
    OP_ST_BB,
    OP_ST_SX,
    OP_ST_E0,
    OP_ST_E1,
    OP_MN_FLAG,
    OP_MN_ERRX,
    OP_MN_ERRY,
    OP_MN_COORD,
    OP_TL_UP,
    OP_TL_LOW
  } op_e;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_RU,
    EM_LU,
    EM_LL,
    EM_RL,
    EM_TU,
    EM_TL,
    EM_ZERO
  } emit_e;

  typedef struct packed {
    seq_e  seq;
    op_e   op;
    emit_e emit;
    logic  last;
  } ucode_t;

  typedef struct packed {
    ucode_t uc;
    logic   fire;
  } ctl_t;

  typedef struct packed {
    logic [PH_BITS-1:0] phase;
    logic               out_free;
  } stat_t;

  function automatic ucode_t ucode_rom(input logic [PC_BITS-1:0] pc);
    ucode_t w;
    w.seq  = SEQ_RET;
    w.op   = OP_NOP;
    w.emit = EM_NONE;
    w.last = 1'b0;
    unique case (pc)
      PC_IDLE: begin
        w.seq = SEQ_WAIT;
        w.op  = OP_LOAD;
      end
      PC_START: begin
        w.seq = SEQ_NEXT;
        w.op  = OP_ST_AA;
      end
      PC_S1: begin
        w.seq = SEQ_NEXT;
        w.op  = OP_ST_BB;
      end
      PC_S2: begin
        w.seq = SEQ_NEXT;
        w.op  = OP_ST_SX;
      end
      PC_S3: begin
        w.seq = SEQ_NEXT;
        w.op  = OP_ST_E0;
      end
      PC_S4: begin
        w.op = OP_ST_E1;
      end
      PC_MAIN: begin
        w.seq  = SEQ_NEXT;
        w.op   = OP_MN_FLAG;
        w.emit = EM_RU;
      end
      PC_M1: begin
        w.seq  = SEQ_NEXT;
        w.op   = OP_MN_ERRX;
        w.emit = EM_LU;
      end
      PC_M2: begin
        w.seq  = SEQ_NEXT;
        w.op   = OP_MN_ERRY;
        w.emit = EM_LL;
      end
      PC_M3: begin
        w.op   = OP_MN_COORD;
        w.emit = EM_RL;
        w.last = 1'b1;
      end
      PC_TAIL: begin
        w.seq  = SEQ_NEXT;
        w.op   = OP_TL_UP;
        w.emit = EM_TU;
      end
      PC_T1: begin
        w.op   = OP_TL_LOW;
        w.emit = EM_TL;
        w.last = 1'b1;
      end
      PC_DONE: begin
        w.emit = EM_ZERO;
        w.last = 1'b1;
      end
      default: begin
        w.seq = SEQ_RET;
      end
    endcase
    return w;
  endfunction

endpackage

>>> hdl/ellipse_rect_rasterizer.sv
// Bresenham outline of an ellipse inscribed in a rectangle.
// Input channel s_*: tuser = 0 starts a new ellipse from the corners in
// tdata, tuser = 1 advances the outline by one step. Output channel m_*:
// one pixel per transfer, tlast on the final pixel of a step, tuser set
// on the single marker transfer a step returns once the outline is done.
// A start transfer returns nothing; once it is accepted, setup runs on one
// shared multiplier before the next transfer is accepted. A main-loop step
// is accepted, then its four pixels move one by one into the output
// register; a tail step returns two pixels and a step after the end returns
// only the done marker. Pixels are registered: each appears in the cycle
// after it is produced. The rate is set by the microcode sequencer,
// which runs one control word per cycle and emits at most one pixel each.
// A stalled receiver holds the output register; the sequencer then waits
// on the pixel-producing step and no new input is accepted meanwhile.
// After reset the outline counts as finished: steps return the done
// marker until a start transfer arrives.
module ellipse_rect_rasterizer #(
  parameter int unsigned COORD_BITS = elr_pkg::COORD_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_tvalid_i,
  output logic                                      s_tready_o,
  // left, top, right, bottom
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]         s_tdata_i,
  // action
  input  logic                                      s_tuser_i,
  output logic                                      m_tvalid_o,
  input  logic                                      m_tready_i,
  // point_x, point_y
  output logic [((2*COORD_BITS+7)/8)*8-1:0]         m_tdata_o,
  output logic                                      m_tlast_o,
  // done_res
  output logic                                      m_tuser_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned OW = ((2*COORD_BITS+7)/8)*8;

  elr_pkg::ctl_t  ctl;
  elr_pkg::stat_t stat;

  logic signed [CB-1:0] point_x, point_y;

  elr_sequencer u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_tvalid_i),
    .action_i  (s_tuser_i),
    .stat_i    (stat),
    .ctl_o     (ctl),
    .s_ready_o (s_tready_o)
  );

  elr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .action_i    (s_tuser_i),
    .x1_i        (s_tdata_i[CB-1:0]),
    .y1_i        (s_tdata_i[2*CB-1:CB]),
    .x2_i        (s_tdata_i[3*CB-1:2*CB]),
    .y2_i        (s_tdata_i[4*CB-1:3*CB]),
    .out_ready_i (m_tready_i),
    .stat_o      (stat),
    .out_valid_o (m_tvalid_o),
    .point_x_o   (point_x),
    .point_y_o   (point_y),
    .last_o      (m_tlast_o),
    .done_o      (m_tuser_o)
  );

  assign m_tdata_o = OW'({point_y, point_x});

endmodule

>>> hdl/elr_sequencer.sv
module elr_sequencer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic          action_i,
  input  elr_pkg::stat_t stat_i,
  output elr_pkg::ctl_t  ctl_o,
  output logic          s_ready_o
);

  logic [elr_pkg::PC_BITS-1:0] pc_q, pc_d;
  logic [elr_pkg::PC_BITS-1:0] dispatch;
  elr_pkg::ucode_t             uc;
  logic                        fire;

  assign uc = elr_pkg::ucode_rom(pc_q);

  always_comb begin
    unique case (uc.seq)
      elr_pkg::SEQ_WAIT: fire = s_valid_i;
      default:           fire = (uc.emit == elr_pkg::EM_NONE) || stat_i.out_free;
    endcase
  end

  always_comb begin
    unique case (stat_i.phase)
      elr_pkg::PH_MAIN: dispatch = elr_pkg::PC_MAIN;
      elr_pkg::PH_TAIL: dispatch = elr_pkg::PC_TAIL;
      default:          dispatch = elr_pkg::PC_DONE;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    unique case (uc.seq)
      elr_pkg::SEQ_WAIT: begin
        if (fire) begin
          pc_d = action_i ? dispatch : elr_pkg::PC_START;
        end
      end
      elr_pkg::SEQ_NEXT: begin
        if (fire) begin
          pc_d = pc_q + elr_pkg::PC_BITS'(1);
        end
      end
      default: begin
        if (fire) begin
          pc_d = elr_pkg::PC_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= elr_pkg::PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctl_o.uc   = uc;
  assign ctl_o.fire = fire;
  assign s_ready_o  = (uc.seq == elr_pkg::SEQ_WAIT);

endmodule

>>> hdl/elr_datapath.sv
module elr_datapath #(
  parameter int unsigned COORD_BITS = elr_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  elr_pkg::ctl_t                ctl_i,
  input  logic                         action_i,
  input  logic signed [COORD_BITS-1:0] x1_i,
  input  logic signed [COORD_BITS-1:0] y1_i,
  input  logic signed [COORD_BITS-1:0] x2_i,
  input  logic signed [COORD_BITS-1:0] y2_i,
  input  logic                         out_ready_i,
  output elr_pkg::stat_t               stat_o,
  output logic                         out_valid_o,
  output logic signed [COORD_BITS-1:0] point_x_o,
  output logic signed [COORD_BITS-1:0] point_y_o,
  output logic                         last_o,
  output logic                         done_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned SQ = 2 * COORD_BITS;
  localparam int unsigned PW = 3 * COORD_BITS + 2;
  localparam int unsigned TB = elr_pkg::TERM_BITS;

  logic signed [CB-1:0] left_q, right_q, upper_q, lower_q;
  logic [CB-1:0]        a_q, span_q;
  logic                 odd_q;
  logic [SQ-1:0]        aa_q, bb_q;
  logic signed [TB-1:0] err_q, sx_q, sy_q, gx_q, gy_q;
  logic                 xs_q, ys_q;
  logic [elr_pkg::PH_BITS-1:0] phase_q;

  logic                 out_valid_q, out_last_q, out_done_q;
  logic signed [CB-1:0] out_x_q, out_y_q;

  logic signed [CB:0]   dx, dy;
  logic signed [CB-1:0] ymin;
  logic [CB:0]          half_b;
  logic signed [CB:0]   one_minus_a;
  logic signed [SQ:0]   mul_a;
  logic signed [CB:0]   mul_b;
  logic signed [PW-1:0] prod;
  logic signed [TB-1:0] prod_t, aa_t, bb_t;
  logic signed [TB:0]   e2, sx_ext, sy_ext;
  logic                 xs, ys;
  logic signed [CB-1:0] nl, nr, nu, nlo, col, tu, tlo;
  logic signed [CB:0]   diff_m, diff_t, span_s;
  logic signed [CB-1:0] em_x, em_y;
  logic                 em_done, load_out;

  assign dx = (x1_i < x2_i) ? ((CB+1)'(x2_i) - (CB+1)'(x1_i))
                            : ((CB+1)'(x1_i) - (CB+1)'(x2_i));
  assign dy = (y1_i < y2_i) ? ((CB+1)'(y2_i) - (CB+1)'(y1_i))
                            : ((CB+1)'(y1_i) - (CB+1)'(y2_i));
  assign ymin = (y1_i < y2_i) ? y1_i : y2_i;

  assign half_b      = ({1'b0, span_q} + (CB+1)'(1)) >> 1;
  assign one_minus_a = (CB+1)'(1) - {1'b0, a_q};

  always_comb begin
    unique case (ctl_i.uc.op)
      elr_pkg::OP_ST_AA: begin
        mul_a = (SQ+1)'(a_q);
        mul_b = {1'b0, a_q};
      end
      elr_pkg::OP_ST_BB: begin
        mul_a = (SQ+1)'(span_q);
        mul_b = {1'b0, span_q};
      end
      default: begin
        mul_a = {1'b0, bb_q};
        mul_b = one_minus_a;
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod_t = TB'(prod);
  assign aa_t   = TB'(aa_q);
  assign bb_t   = TB'(bb_q);

  assign e2     = {err_q, 1'b0};
  assign sx_ext = (TB+1)'(sx_q);
  assign sy_ext = (TB+1)'(sy_q);
  assign xs     = (e2 >= sx_ext);
  assign ys     = (e2 <= sy_ext);

  assign nl     = xs_q ? left_q + 1'b1 : left_q;
  assign nr     = xs_q ? right_q - 1'b1 : right_q;
  assign nu     = ys_q ? upper_q + 1'b1 : upper_q;
  assign nlo    = ys_q ? lower_q - 1'b1 : lower_q;
  assign span_s = {1'b0, span_q};
  assign diff_m = (CB+1)'(nu) - (CB+1)'(nlo);

  assign col    = left_q - 1'b1;
  assign tu     = upper_q + 1'b1;
  assign tlo    = lower_q - 1'b1;
  assign diff_t = (CB+1)'(upper_q) - (CB+1)'(tlo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
      upper_q <= '0;
      lower_q <= '0;
      a_q     <= '0;
      span_q  <= '0;
      odd_q   <= 1'b0;
      aa_q    <= '0;
      bb_q    <= '0;
      err_q   <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      gx_q    <= '0;
      gy_q    <= '0;
      xs_q    <= 1'b0;
      ys_q    <= 1'b0;
      phase_q <= elr_pkg::PH_DONE;
    end else if (ctl_i.fire) begin
      unique case (ctl_i.uc.op)
        elr_pkg::OP_LOAD: begin
          if (!action_i) begin
            left_q  <= (x1_i > x2_i) ? x2_i : x1_i;
            right_q <= (x1_i > x2_i) ? x1_i : x2_i;
            upper_q <= ymin;
            a_q     <= dx[CB-1:0];
            span_q  <= dy[CB-1:0];
            odd_q   <= dy[0];
          end
        end
        elr_pkg::OP_ST_AA: begin
          upper_q <= upper_q + half_b[CB-1:0];
          aa_q    <= prod[SQ-1:0];
        end
        elr_pkg::OP_ST_BB: begin
          lower_q <= upper_q - CB'(odd_q);
          sy_q    <= odd_q ? (aa_t <<< 3) : (aa_t <<< 2);
          gy_q    <= aa_t <<< 3;
          bb_q    <= prod[SQ-1:0];
        end
        elr_pkg::OP_ST_SX: begin
          sx_q <= prod_t <<< 2;
          gx_q <= bb_t <<< 3;
        end
        elr_pkg::OP_ST_E0: begin
          err_q <= sx_q + sy_q;
        end
        elr_pkg::OP_ST_E1: begin
          err_q   <= odd_q ? err_q + aa_t : err_q;
          phase_q <= elr_pkg::PH_MAIN;
        end
        elr_pkg::OP_MN_FLAG: begin
          xs_q <= xs;
          ys_q <= ys;
          if (xs) begin
            sx_q <= sx_q + gx_q;
          end
          if (ys) begin
            sy_q <= sy_q + gy_q;
          end
        end
        elr_pkg::OP_MN_ERRX: begin
          if (xs_q) begin
            err_q <= err_q + sx_q;
          end
        end
        elr_pkg::OP_MN_ERRY: begin
          if (ys_q) begin
            err_q <= err_q + sy_q;
          end
        end
        elr_pkg::OP_MN_COORD: begin
          left_q  <= nl;
          right_q <= nr;
          upper_q <= nu;
          lower_q <= nlo;
          if (!(nl <= nr)) begin
            phase_q <= (diff_m < span_s) ? elr_pkg::PH_TAIL : elr_pkg::PH_DONE;
          end
        end
        elr_pkg::OP_TL_UP: begin
          upper_q <= tu;
        end
        elr_pkg::OP_TL_LOW: begin
          lower_q <= tlo;
          if (!(diff_t < span_s)) begin
            phase_q <= elr_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    em_done = 1'b0;
    unique case (ctl_i.uc.emit)
      elr_pkg::EM_RU: begin
        em_x = right_q;
        em_y = upper_q;
      end
      elr_pkg::EM_LU: begin
        em_x = left_q;
        em_y = upper_q;
      end
      elr_pkg::EM_LL: begin
        em_x = left_q;
        em_y = lower_q;
      end
      elr_pkg::EM_RL: begin
        em_x = right_q;
        em_y = lower_q;
      end
      elr_pkg::EM_TU: begin
        em_x = col;
        em_y = tu;
      end
      elr_pkg::EM_TL: begin
        em_x = col;
        em_y = tlo;
      end
      elr_pkg::EM_ZERO: begin
        em_x    = '0;
        em_y    = '0;
        em_done = 1'b1;
      end
      default: begin
        em_x = '0;
        em_y = '0;
      end
    endcase
  end

  assign load_out = ctl_i.fire && (ctl_i.uc.emit != elr_pkg::EM_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_x_q    <= em_x;
      out_y_q    <= em_y;
      out_last_q <= ctl_i.uc.last;
      out_done_q <= em_done;
    end
  end

  assign stat_o.phase    = phase_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign point_x_o       = out_x_q;
  assign point_y_o       = out_y_q;
  assign last_o          = out_last_q;
  assign done_o          = out_done_q;

endmodule

>>> bench/ellipse_rect_rasterizer_tb.sv
module ellipse_rect_rasterizer_tb;

  localparam int CW = elr_pkg::COORD_BITS_DEF;
  localparam int SDW = ((4*CW+7)/8)*8;
  localparam int MDW = ((2*CW+7)/8)*8;
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP = 1'b1;
  localparam int MAX_GAP = 13;
  localparam int QUIET_LIMIT = 3000;
  localparam int ITEM_TARGET = 480;

  typedef struct packed {
    logic action;
    logic [CW-1:0] left;
    logic [CW-1:0] top;
    logic [CW-1:0] right;
    logic [CW-1:0] bottom;
  } outline_cmd_t;

  typedef struct packed {
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic ends_step;
    logic done_flag;
  } outline_px_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [SDW-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [MDW-1:0] m_tdata;
  logic m_tlast;
  logic m_tuser;

  ellipse_rect_rasterizer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tlast_o  (m_tlast),
    .m_tuser_o  (m_tuser)
  );

  outline_cmd_t cmd_q[$];
  outline_px_t pixel_q[$];

  logic [CW-1:0] col_lo = '0, col_hi = '0, row_up = '0, row_dn = '0;
  longint err_acc = 0, dx_acc = 0, dy_acc = 0, dx_grow = 0, dy_grow = 0;
  int rows_span = 0;
  logic [elr_pkg::PH_BITS-1:0] trace_phase = elr_pkg::PH_DONE;

  int n_items = 0;
  int n_err = 0;
  int n_starts = 0;
  int n_pixels = 0;
  int n_marks = 0;
  int n_tail = 0;
  int quiet_cycles = 0;

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  logic tx_busy = 1'b0;
  logic tx_calm = 1'b0;
  int tx_gap = 0;
  outline_cmd_t tx_cmd = '0;
  logic rx_calm = 1'b0;
  int rx_stall = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint wrap_term(input longint v);
    logic [47:0] t;
    t = v[47:0];
    return longint'($signed(t));
  endfunction

  function automatic int coord(input logic [CW-1:0] v);
    return int'($signed(v));
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, (1 << CW) - 1)) - (1 << (CW - 1));
  endfunction

  function automatic int partner(input int base, input int span);
    if (base + span > (1 << (CW - 1)) - 1) return base - span;
    return base + span;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (n_err < 40) $display("[%0t] mismatch: %s", $realtime, msg);
    n_err++;
  endtask

  task automatic add_start(input int l, input int t, input int r, input int b);
    outline_cmd_t c;
    c.action = ACT_START;
    c.left = CW'(l);
    c.top = CW'(t);
    c.right = CW'(r);
    c.bottom = CW'(b);
    cmd_q.push_back(c);
    n_items++;
  endtask

  task automatic add_steps(input int n);
    outline_cmd_t c;
    repeat (n) begin
      c.action = ACT_STEP;
      c.left = CW'($urandom);
      c.top = CW'($urandom);
      c.right = CW'($urandom);
      c.bottom = CW'($urandom);
      cmd_q.push_back(c);
      n_items++;
    end
  endtask

  task automatic queue_px(input logic [CW-1:0] x, input logic [CW-1:0] y,
                          input logic lst, input logic dn);
    outline_px_t p;
    p.px = x;
    p.py = y;
    p.ends_step = lst;
    p.done_flag = dn;
    pixel_q.push_back(p);
  endtask

  task automatic trace_outline(input outline_cmd_t c);
    int x1, y1, x2, y2, ymin;
    longint a, b, odd, e2;
    logic xs, ys;
    logic [CW-1:0] col;
    if (c.action == ACT_START) begin
      x1 = coord(c.left);
      y1 = coord(c.top);
      x2 = coord(c.right);
      y2 = coord(c.bottom);
      a = (x1 < x2) ? x2 - x1 : x1 - x2;
      b = (y1 < y2) ? y2 - y1 : y1 - y2;
      odd = b & 1;
      ymin = (y1 < y2) ? y1 : y2;
      dx_acc = wrap_term(4 * (1 - a) * b * b);
      dy_acc = wrap_term(4 * (odd + 1) * a * a);
      err_acc = wrap_term(dx_acc + dy_acc + odd * a * a);
      if (x1 > x2) begin
        col_lo = c.right;
        col_hi = c.left;
      end else begin
        col_lo = c.left;
        col_hi = c.right;
      end
      row_up = CW'(longint'(ymin) + (b + 1) / 2);
      row_dn = row_up - CW'(odd);
      dy_grow = wrap_term(8 * a * a);
      dx_grow = wrap_term(8 * b * b);
      rows_span = int'(b);
      trace_phase = elr_pkg::PH_MAIN;
      n_starts++;
    end else if (trace_phase == elr_pkg::PH_MAIN) begin
      e2 = 2 * err_acc;
      xs = (e2 >= dx_acc);
      ys = (e2 <= dy_acc);
      queue_px(col_hi, row_up, 1'b0, 1'b0);
      queue_px(col_lo, row_up, 1'b0, 1'b0);
      queue_px(col_lo, row_dn, 1'b0, 1'b0);
      queue_px(col_hi, row_dn, 1'b1, 1'b0);
      if (xs) begin
        col_lo = col_lo + 1'b1;
        col_hi = col_hi - 1'b1;
        dx_acc = wrap_term(dx_acc + dx_grow);
        err_acc = wrap_term(err_acc + dx_acc);
      end
      if (ys) begin
        row_up = row_up + 1'b1;
        row_dn = row_dn - 1'b1;
        dy_acc = wrap_term(dy_acc + dy_grow);
        err_acc = wrap_term(err_acc + dy_acc);
      end
      if (coord(col_lo) > coord(col_hi))
        trace_phase = (coord(row_up) - coord(row_dn) < rows_span) ?
                      elr_pkg::PH_TAIL : elr_pkg::PH_DONE;
    end else if (trace_phase == elr_pkg::PH_TAIL) begin
      col = col_lo - 1'b1;
      row_up = row_up + 1'b1;
      queue_px(col, row_up, 1'b0, 1'b0);
      row_dn = row_dn - 1'b1;
      queue_px(col, row_dn, 1'b1, 1'b0);
      if (!(coord(row_up) - coord(row_dn) < rows_span)) trace_phase = elr_pkg::PH_DONE;
      n_tail++;
    end else begin
      queue_px('0, '0, 1'b1, 1'b1);
    end
  endtask

  task automatic check_pixel();
    outline_px_t want;
    logic [CW-1:0] got_x, got_y;
    got_x = m_tdata[CW-1:0];
    got_y = m_tdata[2*CW-1:CW];
    if (pixel_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected transfer x=%0d y=%0d last=%0b done=%0b",
                              coord(got_x), coord(got_y), m_tlast, m_tuser));
    end else begin
      want = pixel_q.pop_front();
      if (got_x != want.px)
        flag_mismatch($sformatf("point_x %0d, want %0d", coord(got_x), coord(want.px)));
      if (got_y != want.py)
        flag_mismatch($sformatf("point_y %0d, want %0d", coord(got_y), coord(want.py)));
      if (m_tlast != want.ends_step)
        flag_mismatch($sformatf("last %0b, want %0b", m_tlast, want.ends_step));
      if (m_tuser != want.done_flag)
        flag_mismatch($sformatf("done_res %0b, want %0b", m_tuser, want.done_flag));
      if (want.done_flag) n_marks++;
      else n_pixels++;
    end
  endtask

  // sample both channels, predict and check
  always @(posedge clk_i) begin
    outline_cmd_t c;
    in_taken <= s_tvalid && s_tready;
    out_taken <= m_tvalid && m_tready;
    if (rst_ni) begin
      if (m_tvalid && m_tready) check_pixel();
      if (s_tvalid && s_tready) begin
        c.action = s_tuser;
        c.left = s_tdata[CW-1:0];
        c.top = s_tdata[2*CW-1:CW];
        c.right = s_tdata[3*CW-1:2*CW];
        c.bottom = s_tdata[4*CW-1:3*CW];
        trace_outline(c);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // command driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) tx_busy = 1'b0;
      if (!tx_busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (cmd_q.size() != 0) begin
          tx_cmd = cmd_q.pop_front();
          tx_busy = 1'b1;
          if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
          tx_gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
        end
      end
      s_tvalid <= tx_busy;
      s_tuser <= tx_cmd.action;
      s_tdata <= SDW'({tx_cmd.bottom, tx_cmd.right, tx_cmd.top, tx_cmd.left});
    end
  end

  // pixel receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int pick, wa, hb, x0, y0, xa, ya, n;

    // done marker straight after reset
    add_steps(1);
    add_start(-2048, -2048, 2047, 2047);
    add_steps(2);
    add_start(2047, 2047, -2048, -2048);
    add_steps(1);
    // zero width at the left edge: right column wraps
    add_start(-2048, 5, -2048, 9);
    add_steps(3);
    add_start(0, 0, 0, 0);
    add_steps(2);
    // thin ellipse runs into the tail loop
    add_start(0, 0, 1, 8);
    add_steps(10);
    add_start(5, -2048, 6, 2047);
    add_steps(2);

    while (n_items < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        add_steps($urandom_range(1, 3));
      end else if (pick == 1) begin
        add_start(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        add_steps($urandom_range(1, 6));
      end else begin
        wa = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12);
        hb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12);
        x0 = rand_coord();
        y0 = rand_coord();
        xa = partner(x0, wa);
        ya = partner(y0, hb);
        if ($urandom_range(0, 1)) add_start(x0, y0, xa, ya);
        else add_start(xa, ya, x0, y0);
        n = wa + hb + 3;
        if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
        if (n_items + n > ITEM_TARGET + 8) n = ITEM_TARGET + 8 - n_items;
        add_steps(n);
      end
    end

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || tx_busy || pixel_q.size() != 0) @(negedge clk_i);
    repeat (24) @(negedge clk_i);
    if (pixel_q.size() != 0)
      flag_mismatch($sformatf("%0d expected transfers never arrived", pixel_q.size()));

    $display("covered %0d commands: %0d starts, %0d tail steps", n_items, n_starts, n_tail);
    $display("checked %0d pixels and %0d done markers, %0d mismatches",
             n_pixels, n_marks, n_err);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
